FILE: hdl/gtfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS telemetry frame encoder package
// Frame layout constants, the frame body type and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package gtfe_pkg;

  // Frame layout.
  localparam int unsigned FRAME_LEN   = 18;
  localparam int unsigned BODY_LEN    = FRAME_LEN - 1;
  localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
  localparam int unsigned CRC_FIRST   = 2;
  localparam int unsigned CRC_LAST    = FRAME_LEN - 2;

  localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_CRC_FIRST = IDX_W'(CRC_FIRST);
  localparam logic [IDX_W-1:0] IDX_CRC_LAST  = IDX_W'(CRC_LAST);

  // Fixed header bytes and field constants.
  localparam logic [7:0]  SYNC_BYTE  = 8'hC8;
  localparam logic [7:0]  LEN_BYTE   = 8'h0F;
  localparam logic [7:0]  TYPE_BYTE  = 8'h02;
  localparam logic [15:0] ALT_OFFSET = 16'd1000;
  localparam logic [7:0]  CRC_POLY   = 8'hD5;
  localparam logic [7:0]  CRC_INIT   = 8'h00;

  // Frame body without the CRC byte; element BODY_LEN-1 is sent first.
  typedef logic [BODY_LEN-1:0][7:0] frame_body_t;

  // One byte through the CRC-8, MSB first, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/gtfe_frame_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS telemetry frame builder
// Registers one report beat and assembles the frame body from it.
// ----------------------------------------------------------------------------
module gtfe_frame_build
  import gtfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic        [15:0] ground_speed,
  input  logic        [15:0] course,
  input  logic        [15:0] altitude_m,
  output logic               frm_valid,
  input  logic               frm_ready,
  output frame_body_t        frm_body
);

  logic               hold_valid;
  logic signed [30:0] lat;
  logic signed [31:0] lon;
  logic        [15:0] spd;
  logic        [15:0] crs;
  logic        [15:0] alt;
  logic signed [31:0] lat_ext;
  logic        [15:0] alt_off;

  // The holding register frees up in the same cycle the serializer takes it.
  assign in_ready  = !hold_valid || frm_ready;
  assign frm_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lat <= latitude;
      lon <= longitude;
      spd <= ground_speed;
      crs <= course;
      alt <= altitude_m;
    end
  end

  // Sign-extend latitude and apply the altitude offset, which wraps.
  assign lat_ext = 32'(lat);
  assign alt_off = alt + ALT_OFFSET;

  // Big-endian frame body in send order.
  assign frm_body = {SYNC_BYTE, LEN_BYTE, TYPE_BYTE, lat_ext, lon, spd, crs, alt_off};

endmodule

FILE: hdl/gtfe_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPS telemetry frame serializer
// Shifts the frame body out one byte per beat and appends the running CRC.
// ----------------------------------------------------------------------------
module gtfe_serializer
  import gtfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        frm_valid,
  output logic        frm_ready,
  input  frame_body_t frm_body,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        is_last
);

  logic             busy;
  logic [IDX_W-1:0] idx;
  frame_body_t      body;
  logic [7:0]       crc;
  logic             out_adv;
  logic             at_last;
  logic             in_crc_span;

  // The output register advances when empty or when its beat is taken.
  assign out_adv     = !out_valid || out_ready;
  assign at_last     = (idx == IDX_LAST);
  assign in_crc_span = (idx >= IDX_CRC_FIRST) && (idx <= IDX_CRC_LAST);
  // A new frame loads while the CRC byte of the current one goes out.
  assign frm_ready   = out_adv && (!busy || at_last);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= busy;
      end
      if (frm_valid && frm_ready) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (out_adv && busy) begin
        if (at_last) begin
          busy <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  // Running CRC and output byte.
  always_ff @(posedge clk) begin
    if (out_adv && busy) begin
      if (at_last) begin
        frame_byte <= crc;
        is_last    <= 1'b1;
      end else begin
        frame_byte <= body[BODY_LEN-1];
        is_last    <= 1'b0;
      end
      if (in_crc_span) begin
        crc <= crc8_update(crc, body[BODY_LEN-1]);
      end
    end
    // A new frame takes over the body register; otherwise it shifts by a byte.
    if (frm_valid && frm_ready) begin
      body <= frm_body;
      crc  <= CRC_INIT;
    end else if (out_adv && busy) begin
      body <= {body[BODY_LEN-2:0], 8'h00};
    end
  end

endmodule

FILE: hdl/gps_telemetry_frame_encoder_top.sv
`timescale 1ns / 1ps
// Path: a report beat moves through the holding, body and output registers.
// Throughput: one frame byte per cycle while out_ready is high, set by the
// byte-wide output register; the next report is taken while a frame goes out.
// Reset: synchronous, active high; clears all valid flags and the byte counter.
// ----------------------------------------------------------------------------
// GPS telemetry frame encoder
// Turns one GPS report into an 18-byte telemetry frame closed by a CRC-8.
// ----------------------------------------------------------------------------
module gps_telemetry_frame_encoder_top
  import gtfe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic        [15:0] ground_speed,
  input  logic        [15:0] course,
  input  logic        [15:0] altitude_m,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  frame_byte,
  output logic               is_last
);

  logic        frm_valid;
  logic        frm_ready;
  frame_body_t frm_body;

  // Report register and frame assembly.
  gtfe_frame_build u_build (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .latitude     (latitude),
    .longitude    (longitude),
    .ground_speed (ground_speed),
    .course       (course),
    .altitude_m   (altitude_m),
    .frm_valid    (frm_valid),
    .frm_ready    (frm_ready),
    .frm_body     (frm_body)
  );

  // Byte serializer with running CRC.
  gtfe_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .frm_valid  (frm_valid),
    .frm_ready  (frm_ready),
    .frm_body   (frm_body),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .is_last    (is_last)
  );

endmodule
